>>> hw/rtl/alc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alc_pkg
// Shared widths and helpers for the average-linkage clustering block.
// ----------------------------------------------------------------------------
package alc_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PW         = $clog2(MAX_POINTS);
    localparam int CW         = $clog2(MAX_POINTS + 1);
    localparam int ID_W       = 31;
    localparam int XY_W       = 10;
    localparam int TGT_W      = 7;
    localparam int CN_W       = 6;
    localparam int PT_W       = ID_W + 2 * XY_W;
    localparam int SQ_W       = 2 * XY_W + 1;
    localparam int FRAC_W     = 32;
    localparam int DIST_W     = (SQ_W + FRAC_W + 1) / 2;
    localparam int RAD_W      = 2 * DIST_W;
    localparam int REM_W      = DIST_W + 3;
    localparam int SUM_W      = DIST_W + 2 * PW - 2;
    localparam int DEN_W      = 2 * CW;
    localparam int IT_W       = $clog2(SUM_W + 1);
    localparam int PAIRS      = MAX_POINTS * MAX_POINTS;

    function automatic logic [2*PW-1:0] pair_addr(input logic [PW-1:0] a,
                                                  input logic [PW-1:0] b);
        logic [2*PW-1:0] r;
        if (a < b) begin
            r = {a, b};
        end else begin
            r = {b, a};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/alc_pt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alc_pt_if
// Point item channel: valid/ready with id, coordinates and last mark.
// ----------------------------------------------------------------------------
interface alc_pt_if;
    logic                     valid;
    logic                     ready;
    logic [alc_pkg::ID_W-1:0] point_id;
    logic [alc_pkg::XY_W-1:0] coord_x;
    logic [alc_pkg::XY_W-1:0] coord_y;
    logic                     last_point;

    modport source (output valid, point_id, coord_x, coord_y, last_point, input ready);
    modport sink   (input valid, point_id, coord_x, coord_y, last_point, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/alc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alc_res_if
// Result item channel: valid/ready with cluster number and point.
// ----------------------------------------------------------------------------
interface alc_res_if;
    logic                     valid;
    logic                     ready;
    logic [alc_pkg::CN_W-1:0] cluster_number;
    logic [alc_pkg::ID_W-1:0] out_id;
    logic [alc_pkg::XY_W-1:0] out_x;
    logic [alc_pkg::XY_W-1:0] out_y;
    logic                     cluster_end;
    logic                     run_end;

    modport source (output valid, cluster_number, out_id, out_x, out_y, cluster_end,
                    run_end, input ready);
    modport sink   (input valid, cluster_number, out_id, out_x, out_y, cluster_end,
                    run_end, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/alc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alc_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/average_linkage_clustering.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// average_linkage_clustering
// UPGMA clustering of 2-D points with a shared sqrt/divide sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_pt      in   valid/ready   point_id, coord_x, coord_y, last_point
//  o_res     out  valid/ready   cluster_number, out_id, out_x, out_y, ends
//  cfg       in   i_cfg_we      i_cfg_data = target_clusters
//
//  Points are taken while the block loads; on the last point the block goes busy.
//  Distance fill: n(n-1)/2 pairs, each through a bit-serial sqrt.
//  Each merge: a scan over all active pairs plus one row update per remaining
//  cluster (bit-serial divider), then a relabeling pass over all points.
//  Output: one selection scan over all points per point, held on o_res stall.
//  Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module average_linkage_clustering (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [alc_pkg::TGT_W-1:0]   i_cfg_data,
    alc_pt_if.sink                           i_pt,
    alc_res_if.source                        o_res
);

    localparam int PW     = alc_pkg::PW;
    localparam int CW     = alc_pkg::CW;
    localparam int ID_W   = alc_pkg::ID_W;
    localparam int XY_W   = alc_pkg::XY_W;
    localparam int PT_W   = alc_pkg::PT_W;
    localparam int SQ_W   = alc_pkg::SQ_W;
    localparam int DIST_W = alc_pkg::DIST_W;
    localparam int RAD_W  = alc_pkg::RAD_W;
    localparam int REM_W  = alc_pkg::REM_W;
    localparam int SUM_W  = alc_pkg::SUM_W;
    localparam int DEN_W  = alc_pkg::DEN_W;
    localparam int IT_W   = alc_pkg::IT_W;
    localparam int MAXP   = alc_pkg::MAX_POINTS;
    localparam int CN_W_LOC = alc_pkg::CN_W;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_DP, S_DP_W, S_DQ, S_DQ_W, S_SQ, S_DWR, S_MCHK,
        S_SC, S_SC_CMP, S_MG0, S_MG1, S_MG2, S_MX, S_MX_A, S_MX_B, S_DIV,
        S_MX_WR, S_RL, S_RL_W, S_O_CL, S_O_CNT, S_O_RD, S_O_CMP, S_O_WAIT
    } t_state;

    t_state                    r_state;
    logic [CW-1:0]             r_ld, r_n, r_k, r_p, r_q, r_a, r_b, r_x, r_cnta, r_cleft;
    logic [alc_pkg::TGT_W-1:0] r_target;
    logic [MAXP-1:0]           r_active, r_emit;
    logic [XY_W-1:0]           r_px, r_py;
    logic [RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]          r_rem;
    logic [DIST_W-1:0]         r_root, r_best;
    logic [IT_W-1:0]           r_it;
    logic [SUM_W-1:0]          r_sum, r_num, r_quo;
    logic [DEN_W-1:0]          r_den, r_drem;
    logic                      r_found, r_bfound;
    logic [PW-1:0]             r_ba, r_bb, r_bp, r_cnum;
    logic [ID_W-1:0]           r_bid;
    logic [XY_W-1:0]           r_bx, r_by;
    logic                      r_ov, r_o_cend, r_o_rend;
    logic [CN_W_LOC-1:0]       r_o_cn;
    logic [ID_W-1:0]           r_o_id;
    logic [XY_W-1:0]           r_o_x, r_o_y;

    logic [PT_W-1:0]   pt_rd;
    logic [PW-1:0]     lab_rd;
    logic [CW-1:0]     cnt_rd;
    logic [SUM_W-1:0]  sum_rd;
    logic [DIST_W-1:0] avg_rd;

    logic              pt_we, lab_we, cnt_we, pr_we;
    logic [PW-1:0]     pt_wa, pt_ra, lab_wa, lab_ra, cnt_wa, cnt_ra;
    logic [PW-1:0]     lab_wd;
    logic [CW-1:0]     cnt_wd;
    logic [2*PW-1:0]   pr_wa, sum_ra, avg_ra;
    logic [SUM_W-1:0]  sum_wd;
    logic [DIST_W-1:0] avg_wd;

    logic [ID_W-1:0]   pt_id;
    logic [XY_W-1:0]   pt_x, pt_y, n_dx, n_dy;
    logic [SQ_W-1:0]   n_sq;
    logic [REM_W-1:0]  n_rem2, n_trial;
    logic              n_sq_ge;
    logic [DEN_W:0]    n_drem2;
    logic              n_div_ge;
    logic [CW-1:0]     n_ld, n_tgt, n_cnta;
    logic              full, n_hi, n_cend;

    assign pt_id = pt_rd[PT_W-1 -: ID_W];
    assign pt_x  = pt_rd[2*XY_W-1 -: XY_W];
    assign pt_y  = pt_rd[XY_W-1:0];

    assign full   = (r_ld == CW'(MAXP));
    assign n_ld   = full ? r_ld : r_ld + CW'(1);
    assign n_tgt  = (r_target == '0) ? CW'(1) : CW'(r_target);
    assign n_cnta = r_cnta + cnt_rd;
    assign n_cend = (r_cleft == CW'(1));

    always_comb begin
        n_dx    = (r_px > pt_x) ? r_px - pt_x : pt_x - r_px;
        n_dy    = (r_py > pt_y) ? r_py - pt_y : pt_y - r_py;
        n_sq    = SQ_W'(n_dx * n_dx) + SQ_W'(n_dy * n_dy);
        n_rem2  = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        n_trial = REM_W'({r_root, 2'b01});
        n_sq_ge = (n_rem2 >= n_trial);
        n_drem2 = {r_drem, r_num[SUM_W-1]};
        n_div_ge = (n_drem2 >= {1'b0, r_den});
        n_hi = 1'b0;
        for (int i = 0; i < MAXP; i++) begin
            if (r_active[i] && (CW'(i) > r_a)) begin
                n_hi = 1'b1;
            end
        end
    end

    always_comb begin
        pt_we  = (r_state == S_LOAD) && i_pt.valid && !full;
        pt_wa  = r_ld[PW-1:0];
        pt_ra  = (r_state == S_DQ) ? r_q[PW-1:0] : r_p[PW-1:0];
        lab_we = (r_state == S_INIT && r_p < r_n) || (r_state == S_RL_W && lab_rd == r_bb);
        lab_wa = r_p[PW-1:0];
        lab_wd = (r_state == S_INIT) ? r_p[PW-1:0] : r_ba;
        lab_ra = r_p[PW-1:0];
        cnt_we = (r_state == S_INIT && r_p < r_n) || (r_state == S_MG2);
        cnt_wa = (r_state == S_INIT) ? r_p[PW-1:0] : r_ba;
        cnt_wd = (r_state == S_INIT) ? CW'(1) : n_cnta;
        unique case (r_state)
            S_MG0:   cnt_ra = r_ba;
            S_MG1:   cnt_ra = r_bb;
            S_MX:    cnt_ra = r_x[PW-1:0];
            default: cnt_ra = r_a[PW-1:0];
        endcase
        pr_we  = (r_state == S_DWR) || (r_state == S_MX_WR);
        pr_wa  = (r_state == S_DWR) ? alc_pkg::pair_addr(r_p[PW-1:0], r_q[PW-1:0])
                                    : alc_pkg::pair_addr(r_ba, r_x[PW-1:0]);
        sum_wd = (r_state == S_DWR) ? SUM_W'(r_root) : r_sum;
        avg_wd = (r_state == S_DWR) ? r_root : r_quo[DIST_W-1:0];
        sum_ra = (r_state == S_MX_A) ? alc_pkg::pair_addr(r_bb, r_x[PW-1:0])
                                     : alc_pkg::pair_addr(r_ba, r_x[PW-1:0]);
        avg_ra = alc_pkg::pair_addr(r_a[PW-1:0], r_b[PW-1:0]);
    end

    alc_ram #(.WIDTH(PT_W), .DEPTH(MAXP)) u_pt_ram (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_wa),
        .i_wdata({i_pt.point_id, i_pt.coord_x, i_pt.coord_y}),
        .i_raddr(pt_ra), .o_rdata(pt_rd));

    alc_ram #(.WIDTH(PW), .DEPTH(MAXP)) u_lab_ram (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(lab_wa), .i_wdata(lab_wd),
        .i_raddr(lab_ra), .o_rdata(lab_rd));

    alc_ram #(.WIDTH(CW), .DEPTH(MAXP)) u_cnt_ram (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_raddr(cnt_ra), .o_rdata(cnt_rd));

    alc_ram #(.WIDTH(SUM_W), .DEPTH(alc_pkg::PAIRS)) u_sum_ram (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_wa), .i_wdata(sum_wd),
        .i_raddr(sum_ra), .o_rdata(sum_rd));

    alc_ram #(.WIDTH(DIST_W), .DEPTH(alc_pkg::PAIRS)) u_avg_ram (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_wa), .i_wdata(avg_wd),
        .i_raddr(avg_ra), .o_rdata(avg_rd));

    assign i_pt.ready           = (r_state == S_LOAD);
    assign o_res.valid          = r_ov;
    assign o_res.cluster_number = r_o_cn;
    assign o_res.out_id         = r_o_id;
    assign o_res.out_x          = r_o_x;
    assign o_res.out_y          = r_o_y;
    assign o_res.cluster_end    = r_o_cend;
    assign o_res.run_end        = r_o_rend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ld     <= '0;
            r_ov     <= 1'b0;
            r_target <= alc_pkg::TGT_W'(1);
            r_active <= '0;
            r_emit   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_pt.valid) begin
                        r_ld <= n_ld;
                        if (i_pt.last_point) begin
                            r_n      <= n_ld;
                            r_active <= '0;
                            r_p      <= '0;
                            r_state  <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (r_p >= r_n) begin
                        r_p     <= '0;
                        r_k     <= r_n;
                        r_state <= S_DP;
                    end else begin
                        r_active[r_p[PW-1:0]] <= 1'b1;
                        r_p <= r_p + CW'(1);
                    end
                end
                S_DP: begin
                    if ((r_p + CW'(1)) >= r_n) begin
                        r_state <= S_MCHK;
                    end else begin
                        r_state <= S_DP_W;
                    end
                end
                S_DP_W: begin
                    r_px    <= pt_x;
                    r_py    <= pt_y;
                    r_q     <= r_p + CW'(1);
                    r_state <= S_DQ;
                end
                S_DQ: begin
                    if (r_q >= r_n) begin
                        r_p     <= r_p + CW'(1);
                        r_state <= S_DP;
                    end else begin
                        r_state <= S_DQ_W;
                    end
                end
                S_DQ_W: begin
                    r_rad   <= RAD_W'({n_sq, alc_pkg::FRAC_W'(0)});
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_it    <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                    r_rem  <= n_sq_ge ? n_rem2 - n_trial : n_rem2;
                    r_root <= {r_root[DIST_W-2:0], n_sq_ge};
                    r_it   <= r_it + IT_W'(1);
                    if (r_it == IT_W'(DIST_W - 1)) begin
                        r_state <= S_DWR;
                    end
                end
                S_DWR: begin
                    r_q     <= r_q + CW'(1);
                    r_state <= S_DQ;
                end
                S_MCHK: begin
                    if (r_k > n_tgt && r_k >= CW'(2)) begin
                        r_a     <= '0;
                        r_b     <= CW'(1);
                        r_found <= 1'b0;
                        r_state <= S_SC;
                    end else begin
                        r_a     <= '0;
                        r_cnum  <= '0;
                        r_emit  <= '0;
                        r_state <= S_O_CL;
                    end
                end
                S_SC: begin
                    if ((r_a + CW'(1)) >= r_n) begin
                        r_state <= S_MG0;
                    end else if (r_b >= r_n) begin
                        r_a <= r_a + CW'(1);
                        r_b <= r_a + CW'(2);
                    end else if (r_active[r_a[PW-1:0]] && r_active[r_b[PW-1:0]]) begin
                        r_state <= S_SC_CMP;
                    end else begin
                        r_b <= r_b + CW'(1);
                    end
                end
                S_SC_CMP: begin
                    if (!r_found || avg_rd < r_best) begin
                        r_found <= 1'b1;
                        r_best  <= avg_rd;
                        r_ba    <= r_a[PW-1:0];
                        r_bb    <= r_b[PW-1:0];
                    end
                    r_b     <= r_b + CW'(1);
                    r_state <= S_SC;
                end
                S_MG0: begin
                    r_state <= S_MG1;
                end
                S_MG1: begin
                    r_cnta  <= cnt_rd;
                    r_state <= S_MG2;
                end
                S_MG2: begin
                    r_cnta         <= n_cnta;
                    r_active[r_bb] <= 1'b0;
                    r_x            <= '0;
                    r_state        <= S_MX;
                end
                S_MX: begin
                    if (r_x >= r_n) begin
                        r_p     <= '0;
                        r_state <= S_RL;
                    end else if (r_active[r_x[PW-1:0]] && r_x[PW-1:0] != r_ba) begin
                        r_state <= S_MX_A;
                    end else begin
                        r_x <= r_x + CW'(1);
                    end
                end
                S_MX_A: begin
                    r_sum   <= sum_rd;
                    r_den   <= DEN_W'(r_cnta) * DEN_W'(cnt_rd);
                    r_state <= S_MX_B;
                end
                S_MX_B: begin
                    r_sum   <= r_sum + sum_rd;
                    r_num   <= r_sum + sum_rd;
                    r_drem  <= '0;
                    r_it    <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num  <= {r_num[SUM_W-2:0], 1'b0};
                    r_drem <= n_div_ge ? DEN_W'(n_drem2 - {1'b0, r_den}) : DEN_W'(n_drem2);
                    r_quo  <= {r_quo[SUM_W-2:0], n_div_ge};
                    r_it   <= r_it + IT_W'(1);
                    if (r_it == IT_W'(SUM_W - 1)) begin
                        r_state <= S_MX_WR;
                    end
                end
                S_MX_WR: begin
                    r_x     <= r_x + CW'(1);
                    r_state <= S_MX;
                end
                S_RL: begin
                    if (r_p >= r_n) begin
                        r_k     <= r_k - CW'(1);
                        r_state <= S_MCHK;
                    end else begin
                        r_state <= S_RL_W;
                    end
                end
                S_RL_W: begin
                    r_p     <= r_p + CW'(1);
                    r_state <= S_RL;
                end
                S_O_CL: begin
                    if (r_a >= r_n) begin
                        r_ld    <= '0;
                        r_state <= S_LOAD;
                    end else if (!r_active[r_a[PW-1:0]]) begin
                        r_a <= r_a + CW'(1);
                    end else begin
                        r_state <= S_O_CNT;
                    end
                end
                S_O_CNT: begin
                    r_cleft  <= cnt_rd;
                    r_p      <= '0;
                    r_bfound <= 1'b0;
                    r_state  <= S_O_RD;
                end
                S_O_RD: begin
                    if (r_p >= r_n) begin
                        r_ov         <= 1'b1;
                        r_o_cn       <= r_cnum;
                        r_o_id       <= r_bid;
                        r_o_x        <= r_bx;
                        r_o_y        <= r_by;
                        r_o_cend     <= n_cend;
                        r_o_rend     <= n_cend && !n_hi;
                        r_emit[r_bp] <= 1'b1;
                        r_cleft      <= r_cleft - CW'(1);
                        r_state      <= S_O_WAIT;
                    end else begin
                        r_state <= S_O_CMP;
                    end
                end
                S_O_CMP: begin
                    if (lab_rd == r_a[PW-1:0] && !r_emit[r_p[PW-1:0]] &&
                        (!r_bfound || pt_id < r_bid)) begin
                        r_bfound <= 1'b1;
                        r_bid    <= pt_id;
                        r_bx     <= pt_x;
                        r_by     <= pt_y;
                        r_bp     <= r_p[PW-1:0];
                    end
                    r_p     <= r_p + CW'(1);
                    r_state <= S_O_RD;
                end
                S_O_WAIT: begin
                    if (o_res.ready) begin
                        r_ov <= 1'b0;
                        if (r_cleft == '0) begin
                            r_cnum  <= r_cnum + PW'(1);
                            r_a     <= r_a + CW'(1);
                            r_state <= S_O_CL;
                        end else begin
                            r_p      <= '0;
                            r_bfound <= 1'b0;
                            r_state  <= S_O_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/alc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alc_checker
// Port-level checks for the clustering block, bound to the top level.
// ----------------------------------------------------------------------------
module alc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_pt_ready,
    input wire logic i_res_valid,
    input wire logic i_res_ready,
    input wire logic i_res_cend,
    input wire logic i_res_rend
);

    a_busy_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pt_ready && i_res_valid))
        else $error("point input open while a result item is pending");

    a_rend_cend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_rend |-> i_res_cend)
        else $error("run end without cluster end");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result item dropped before taken");

    a_rend_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && i_res_rend |=> !i_res_valid)
        else $error("result item follows run end");

endmodule

bind average_linkage_clustering alc_checker u_alc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pt_ready  (i_pt.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_cend  (o_res.cluster_end),
    .i_res_rend  (o_res.run_end)
);
`default_nettype wire
